// ===== rtl/core/mpgw_pkg.sv =====
package mpgw_pkg;

  localparam int GRAPH_NODES     = 8;
  localparam int GAIN_WIDTH      = 3;
  localparam int BEST_WIDTH      = 16;
  localparam int COUNT_WIDTH     = 4;
  localparam int EDGE_WIDTH      = GRAPH_NODES * GRAPH_NODES;
  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 64;

  localparam int DEFAULT_MAX_NODES   = 8;
  localparam int DEFAULT_TOTAL_WIDTH = 16;

  localparam logic [COUNT_WIDTH-1:0] NODE_COUNT_RESET = COUNT_WIDTH'(GRAPH_NODES);

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_EDGE_MATRIX = 2'd0,
    REG_NODE_COUNT  = 2'd1
  } cfg_reg_t;

  typedef struct packed {
    logic                  first_step;
    logic [GAIN_WIDTH-1:0] gain_node0;
    logic [GAIN_WIDTH-1:0] gain_node1;
    logic [GAIN_WIDTH-1:0] gain_node2;
    logic [GAIN_WIDTH-1:0] gain_node3;
    logic [GAIN_WIDTH-1:0] gain_node4;
    logic [GAIN_WIDTH-1:0] gain_node5;
    logic [GAIN_WIDTH-1:0] gain_node6;
    logic [GAIN_WIDTH-1:0] gain_node7;
  } in_item_t;

  typedef struct packed {
    logic [BEST_WIDTH-1:0]  best_total;
    logic [GRAPH_NODES-1:0] reachable_mask;
  } out_item_t;

  typedef struct packed {
    logic                   first_step;
    logic [GRAPH_NODES-1:0] active;
    logic [GRAPH_NODES-1:0] reached;
  } lane_ctl_t;

endpackage

// ===== rtl/core/mpgw_lane.sv =====
module mpgw_lane
  import mpgw_pkg::*;
#(
  parameter int LANES       = DEFAULT_MAX_NODES,
  parameter int TOTAL_WIDTH = DEFAULT_TOTAL_WIDTH,
  parameter int LANE_INDEX  = 0
) (
  input  lane_ctl_t                         ctl,
  input  logic [EDGE_WIDTH-1:0]             edges,
  input  logic [GAIN_WIDTH-1:0]             gain,
  input  logic [LANES-1:0][TOTAL_WIDTH-1:0] totals,
  output logic                              reach,
  output logic [TOTAL_WIDTH-1:0]            total
);

  logic                   found;
  logic [TOTAL_WIDTH-1:0] best_pred;
  logic [TOTAL_WIDTH:0]   sum;

  always_comb begin
    found     = 1'b0;
    best_pred = '0;
    for (int i = 0; i < LANES; i++) begin
      if (ctl.reached[i] && ctl.active[i] &&
          ((i == LANE_INDEX) || edges[i * GRAPH_NODES + LANE_INDEX])) begin
        found = 1'b1;
        if (totals[i] > best_pred) begin
          best_pred = totals[i];
        end
      end
    end
  end

  assign sum = {1'b0, best_pred} + (TOTAL_WIDTH + 1)'(gain);

  always_comb begin
    if (ctl.first_step) begin
      reach = ctl.active[LANE_INDEX] && ((LANE_INDEX == 0) || edges[LANE_INDEX]);
      total = reach ? TOTAL_WIDTH'(gain) : '0;
    end else begin
      reach = ctl.active[LANE_INDEX] && found;
      if (!reach) begin
        total = '0;
      end else if (sum[TOTAL_WIDTH]) begin
        total = '1;
      end else begin
        total = sum[TOTAL_WIDTH-1:0];
      end
    end
  end

endmodule

// ===== rtl/core/mpgw_merge.sv =====
module mpgw_merge
  import mpgw_pkg::*;
#(
  parameter int LANES       = DEFAULT_MAX_NODES,
  parameter int TOTAL_WIDTH = DEFAULT_TOTAL_WIDTH
) (
  input  logic [LANES-1:0][TOTAL_WIDTH-1:0] totals,
  input  logic [LANES-1:0]                  reached,
  output out_item_t                         result
);

  logic [TOTAL_WIDTH-1:0] best;

  always_comb begin
    best = '0;
    for (int i = 0; i < LANES; i++) begin
      if (reached[i] && (totals[i] > best)) begin
        best = totals[i];
      end
    end
  end

  assign result.best_total     = BEST_WIDTH'(best);
  assign result.reachable_mask = GRAPH_NODES'(reached);

endmodule

// ===== rtl/core/max_plus_graph_week_dp_unit.sv =====
// Channel   Direction  Handshake              Payload
// in        input      in_valid / in_ready    in_item (in_item_t)
// out       output     out_valid / out_ready  out_item (out_item_t)
// cfg       input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One transaction per cycle unless output stalls; results pass node_total, then out_item.
// All lanes update their node totals in the accepting cycle; the merge stage reads them next.
// Synchronous reset clears totals, reach mask, edges and sets node count to eight.
// A stalled output holds the merge stage, which in turn holds the input.
// cfg_ready is always high.
module max_plus_graph_week_dp_unit
  import mpgw_pkg::*;
#(
  parameter int MAX_NODES   = DEFAULT_MAX_NODES,
  parameter int TOTAL_WIDTH = DEFAULT_TOTAL_WIDTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_item,
  output logic                       out_valid,
  input  logic                       out_ready,
  output out_item_t                  out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int LANES = (MAX_NODES < GRAPH_NODES) ? MAX_NODES : GRAPH_NODES;

  logic [EDGE_WIDTH-1:0]             edge_matrix;
  logic [COUNT_WIDTH-1:0]            node_count;
  logic [LANES-1:0][TOTAL_WIDTH-1:0] node_total;
  logic [LANES-1:0]                  node_reached;
  logic                              merge_valid;

  logic [COUNT_WIDTH-1:0]            count_used;
  logic [GRAPH_NODES-1:0][GAIN_WIDTH-1:0] gains;
  lane_ctl_t                         ctl;
  logic [LANES-1:0][TOTAL_WIDTH-1:0] node_total_next;
  logic [LANES-1:0]                  node_reached_next;
  out_item_t                         merged;
  logic                              merge_ready;
  logic                              in_fire;

  assign cfg_ready   = 1'b1;
  assign merge_ready = !out_valid || out_ready;
  assign in_ready    = !merge_valid || merge_ready;
  assign in_fire     = in_valid && in_ready;

  always_comb begin
    if (node_count == '0) begin
      count_used = COUNT_WIDTH'(1);
    end else if (node_count > COUNT_WIDTH'(LANES)) begin
      count_used = COUNT_WIDTH'(LANES);
    end else begin
      count_used = node_count;
    end
  end

  assign gains[0] = in_item.gain_node0;
  assign gains[1] = in_item.gain_node1;
  assign gains[2] = in_item.gain_node2;
  assign gains[3] = in_item.gain_node3;
  assign gains[4] = in_item.gain_node4;
  assign gains[5] = in_item.gain_node5;
  assign gains[6] = in_item.gain_node6;
  assign gains[7] = in_item.gain_node7;

  always_comb begin
    ctl.first_step = in_item.first_step;
    ctl.reached    = GRAPH_NODES'(node_reached);
    for (int i = 0; i < GRAPH_NODES; i++) begin
      ctl.active[i] = (COUNT_WIDTH'(i) < count_used) && (i < LANES);
    end
  end

  for (genvar j = 0; j < LANES; j++) begin : g_lane
    mpgw_lane #(
      .LANES      (LANES),
      .TOTAL_WIDTH(TOTAL_WIDTH),
      .LANE_INDEX (j)
    ) u_lane (
      .ctl   (ctl),
      .edges (edge_matrix),
      .gain  (gains[j]),
      .totals(node_total),
      .reach (node_reached_next[j]),
      .total (node_total_next[j])
    );
  end

  mpgw_merge #(
    .LANES      (LANES),
    .TOTAL_WIDTH(TOTAL_WIDTH)
  ) u_merge (
    .totals (node_total),
    .reached(node_reached),
    .result (merged)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_matrix <= '0;
      node_count  <= NODE_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_EDGE_MATRIX: edge_matrix <= cfg_data[EDGE_WIDTH-1:0];
        REG_NODE_COUNT:  node_count  <= cfg_data[COUNT_WIDTH-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      node_total   <= '0;
      node_reached <= '0;
      merge_valid  <= 1'b0;
    end else begin
      if (in_fire) begin
        node_total   <= node_total_next;
        node_reached <= node_reached_next;
        merge_valid  <= 1'b1;
      end else if (merge_ready) begin
        merge_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (merge_ready) begin
      out_valid <= merge_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (merge_ready && merge_valid) begin
      out_item <= merged;
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import mpgw_pkg::*;

  typedef enum logic [1:0] {
    ROW_STEP,
    ROW_EDGES,
    ROW_COUNT
  } row_kind_t;

  typedef struct packed {
    row_kind_t                 kind;
    logic [CFG_DATA_WIDTH-1:0] value;
    in_item_t                  step;
    logic                      fixed;
    out_item_t                 want;
  } row_t;

  localparam int ROWS = 26;
  localparam int SAT_STEPS = 100;
  localparam int PHASES = 6;
  localparam int PHASE_STEPS = 105;

  localparam row_t SCRIPT [ROWS] = '{
    '{ROW_STEP,  64'd0, {1'b0, 24'o77777777}, 1'b1, {16'd0,  8'h00}},
    '{ROW_STEP,  64'd0, {1'b1, 24'o57777777}, 1'b1, {16'd5,  8'h01}},
    '{ROW_STEP,  64'd0, {1'b0, 24'o77777777}, 1'b1, {16'd12, 8'h01}},
    '{ROW_EDGES, {64{1'b1}}, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b1, 24'o01234567}, 1'b1, {16'd7,  8'hFF}},
    '{ROW_STEP,  64'd0, {1'b0, 24'o77777777}, 1'b1, {16'd14, 8'hFF}},
    '{ROW_STEP,  64'd0, {1'b0, 24'o00000000}, 1'b0, 24'd0},
    '{ROW_COUNT, 64'd0, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b1, 24'o77777777}, 1'b1, {16'd7,  8'h01}},
    '{ROW_STEP,  64'd0, {1'b0, 24'o34343434}, 1'b0, 24'd0},
    '{ROW_COUNT, 64'd15, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b1, 24'o00000000}, 1'b1, {16'd0,  8'hFF}},
    '{ROW_STEP,  64'd0, {1'b0, 24'o16253470}, 1'b0, 24'd0},
    '{ROW_EDGES, 64'h8000_0000_0008_0423, 25'd0, 1'b0, 24'd0},
    '{ROW_COUNT, 64'd4, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b1, 24'o23456712}, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b0, 24'o77777777}, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b0, 24'o70707070}, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b0, 24'o07070707}, 1'b0, 24'd0},
    '{ROW_EDGES, 64'd0, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b0, 24'o12345670}, 1'b0, 24'd0},
    '{ROW_COUNT, 64'd1, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b1, 24'o70000000}, 1'b1, {16'd7,  8'h01}},
    '{ROW_STEP,  64'd0, {1'b0, 24'o77777777}, 1'b1, {16'd14, 8'h01}},
    '{ROW_COUNT, 64'd8, 25'd0, 1'b0, 24'd0},
    '{ROW_STEP,  64'd0, {1'b0, 24'o55555555}, 1'b0, 24'd0}
  };

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  in_item_t                   in_item = '0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  out_item_t                  out_item;
  logic                       cfg_valid = 1'b0;
  logic                       cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;

  logic [EDGE_WIDTH-1:0]  edge_bits = '0;
  logic [COUNT_WIDTH-1:0] count_cfg = NODE_COUNT_RESET;
  logic [BEST_WIDTH-1:0]  node_value [GRAPH_NODES] = '{default: '0};
  logic [GRAPH_NODES-1:0] node_live = '0;

  out_item_t awaited_results [$];
  int        mismatches = 0;
  int        results_taken = 0;
  int        sender_ceiling = 16;
  int        receiver_ceiling = 16;

  max_plus_graph_week_dp_unit dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_item (out_item),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic out_item_t advance_graph(in_item_t step);
    logic [GAIN_WIDTH-1:0]  gain [GRAPH_NODES];
    logic [BEST_WIDTH-1:0]  fresh [GRAPH_NODES];
    logic [GRAPH_NODES-1:0] fresh_live;
    logic [BEST_WIDTH-1:0]  peak;
    logic [BEST_WIDTH-1:0]  best;
    logic [BEST_WIDTH:0]    sum;
    bit                     found;
    int                     span;
    out_item_t              res;
    gain = '{step.gain_node0, step.gain_node1, step.gain_node2, step.gain_node3,
             step.gain_node4, step.gain_node5, step.gain_node6, step.gain_node7};
    span = (count_cfg == 0) ? 1 : ((count_cfg > GRAPH_NODES) ? GRAPH_NODES : int'(count_cfg));
    fresh_live = '0;
    best = '0;
    for (int j = 0; j < GRAPH_NODES; j++) fresh[j] = '0;
    for (int j = 0; j < span; j++) begin
      if (step.first_step) begin
        if (j == 0 || edge_bits[j]) begin
          fresh[j] = BEST_WIDTH'(gain[j]);
          fresh_live[j] = 1'b1;
        end
      end else begin
        found = 1'b0;
        peak = '0;
        for (int i = 0; i < span; i++) begin
          if (node_live[i] && (i == j || edge_bits[i * GRAPH_NODES + j]) &&
              (!found || node_value[i] > peak)) begin
            peak = node_value[i];
            found = 1'b1;
          end
        end
        if (found) begin
          sum = peak + gain[j];
          fresh[j] = sum[BEST_WIDTH] ? {BEST_WIDTH{1'b1}} : sum[BEST_WIDTH-1:0];
          fresh_live[j] = 1'b1;
        end
      end
    end
    for (int i = 0; i < GRAPH_NODES; i++) begin
      node_value[i] = fresh[i];
      if (fresh_live[i] && fresh[i] > best) best = fresh[i];
    end
    node_live = fresh_live;
    res.best_total = best;
    res.reachable_mask = fresh_live;
    return res;
  endfunction

  function automatic int idle_ceiling();
    case ($urandom_range(2, 0))
      0: return 0;
      1: return 4;
      default: return 16;
    endcase
  endfunction

  task automatic flag_mismatch(string what);
    mismatches++;
    if (mismatches <= 40) $display("%0t mismatch: %s", $realtime, what);
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (awaited_results.size() == 0) begin
      flag_mismatch($sformatf("unexpected result best_total %0d mask %h",
                              got.best_total, got.reachable_mask));
      return;
    end
    want = awaited_results.pop_front();
    if (got.best_total !== want.best_total)
      flag_mismatch($sformatf("best_total got %0d want %0d", got.best_total, want.best_total));
    if (got.reachable_mask !== want.reachable_mask)
      flag_mismatch($sformatf("reachable_mask got %h want %h",
                              got.reachable_mask, want.reachable_mask));
  endtask

  task automatic offer_step(in_item_t step, logic fixed, out_item_t want);
    int gap;
    out_item_t predicted;
    if ($urandom_range(31, 0) == 0) sender_ceiling = idle_ceiling();
    gap = $urandom_range(sender_ceiling, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_item <= step;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predicted = advance_graph(step);
    awaited_results.push_back(fixed ? want : predicted);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_WIDTH-1:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_EDGE_MATRIX) edge_bits = data[EDGE_WIDTH-1:0];
    else count_cfg = data[COUNT_WIDTH-1:0];
    @(posedge clk);
  endtask

  initial begin : result_side
    int stall;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(31, 0) == 0) receiver_ceiling = idle_ceiling();
      stall = $urandom_range(receiver_ceiling, 0);
      if (results_taken == 150 || results_taken == 600) stall = 120;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_result(out_item);
      results_taken++;
    end
  end

  initial begin : stimulus
    int left;
    logic first;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int r = 0; r < ROWS; r++) begin
      case (SCRIPT[r].kind)
        ROW_EDGES: begin
          settle();
          write_reg(REG_EDGE_MATRIX, SCRIPT[r].value);
        end
        ROW_COUNT: begin
          settle();
          write_reg(REG_NODE_COUNT, SCRIPT[r].value);
        end
        default: offer_step(SCRIPT[r].step, SCRIPT[r].fixed, SCRIPT[r].want);
      endcase
    end

    // drive node 0 through a long chain of steps at full gain
    settle();
    write_reg(REG_EDGE_MATRIX, '0);
    write_reg(REG_NODE_COUNT, CFG_DATA_WIDTH'(1));
    offer_step({1'b1, 3'd7, 21'($urandom)}, 1'b0, '0);
    for (int k = 0; k < SAT_STEPS; k++) offer_step({1'b0, 3'd7, 21'($urandom)}, 1'b0, '0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      case (p % 4)
        0: write_reg(REG_EDGE_MATRIX, {CFG_DATA_WIDTH{1'b1}});
        1: write_reg(REG_EDGE_MATRIX, '0);
        2: write_reg(REG_EDGE_MATRIX, {$urandom, $urandom});
        default: write_reg(REG_EDGE_MATRIX, {$urandom, $urandom} & {$urandom, $urandom});
      endcase
      case (p)
        0: write_reg(REG_NODE_COUNT, CFG_DATA_WIDTH'(8));
        1: write_reg(REG_NODE_COUNT, CFG_DATA_WIDTH'(1));
        default: write_reg(REG_NODE_COUNT, CFG_DATA_WIDTH'($urandom_range(15, 0)));
      endcase
      left = 0;
      for (int k = 0; k < PHASE_STEPS; k++) begin
        if (left == 0) begin
          first = 1'b1;
          left = $urandom_range(24, 1);
        end else begin
          first = ($urandom_range(15, 0) == 0);
          left--;
        end
        offer_step({first, 24'($urandom)}, 1'b0, '0);
        if ($urandom_range(99, 0) == 0) settle();
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS max_plus_graph_week_dp_unit");
    end else begin
      $display("FAIL max_plus_graph_week_dp_unit");
    end
    $finish;
  end

  initial begin : watchdog
    #6000000;
    $display("FAIL max_plus_graph_week_dp_unit");
    $finish;
  end

endmodule
